>>> hw/rtl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// Profile column scorer package
// Shared widths, request and register codes, and the divider handshake types.
// ----------------------------------------------------------------------------
package pcs_pkg;

	localparam int MAX_ALPHABET = 32;
	localparam int ENTRY_BITS   = 8;
	localparam int FREQ_BITS    = 16;

	localparam int RES_W    = $clog2(MAX_ALPHABET);
	localparam int CNT_W    = $clog2(MAX_ALPHABET + 1);
	localparam int TBL_AW   = 2 * RES_W;
	localparam int TBL_DEPTH = 1 << TBL_AW;

	localparam int ALPHA_W  = 6;
	localparam int SCALE_W  = 16;
	localparam int SCORE_W  = 32;
	localparam int CFG_DW   = 32;
	localparam int CFG_IW   = 2;
	localparam int SCALE_FRAC = 8;

	localparam int PROD_W   = FREQ_BITS + 1 + ENTRY_BITS;
	localparam int ACC_W    = PROD_W + RES_W;
	localparam int DVD_W    = ((ACC_W + SCALE_FRAC + 1) / 2) * 2;
	localparam int DIV_STEPS = DVD_W / 2;
	localparam int DIV_CW   = $clog2(DIV_STEPS);

	localparam logic REQ_MATRIX = 1'b0;
	localparam logic REQ_FREQ   = 1'b1;

	localparam logic [CFG_IW-1:0] CFG_ALPHABET = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_SCALE    = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_MASK     = 2'd2;

	localparam logic [ALPHA_W-1:0] ALPHA_RST = 6'd20;
	localparam logic [SCALE_W-1:0] SCALE_RST = 16'd256;

	typedef struct packed {
		logic                    start;
		logic signed [ACC_W-1:0] acc;
		logic [SCALE_W-1:0]      divisor;
	} div_cmd_t;

	typedef struct packed {
		logic                      done;
		logic signed [SCORE_W-1:0] score;
	} div_rsp_t;

endpackage

>>> hw/rtl/pcs_in_if.sv
// ----------------------------------------------------------------------------
// Profile column scorer request channel
// Valid/ready channel carrying matrix writes and column frequencies.
// ----------------------------------------------------------------------------
interface pcs_in_if import pcs_pkg::*;;
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic [RES_W-1:0]             row_residue;
	logic [RES_W-1:0]             col_residue;
	logic signed [ENTRY_BITS-1:0] matrix_entry;
	logic [FREQ_BITS-1:0]         frequency;

	modport source (
		output valid, req_type, row_residue, col_residue, matrix_entry, frequency,
		input  ready
	);
	modport sink (
		input  valid, req_type, row_residue, col_residue, matrix_entry, frequency,
		output ready
	);
endinterface

>>> hw/rtl/pcs_out_if.sv
// ----------------------------------------------------------------------------
// Profile column scorer result channel
// Valid/ready channel carrying one residue score per transfer.
// ----------------------------------------------------------------------------
interface pcs_out_if import pcs_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [RES_W-1:0]          residue;
	logic signed [SCORE_W-1:0] score;
	logic                      masked;
	logic                      last_of_column;

	modport source (
		output valid, residue, score, masked, last_of_column,
		input  ready
	);
	modport sink (
		input  valid, residue, score, masked, last_of_column,
		output ready
	);
endinterface

>>> hw/rtl/pcs_div.sv
// ----------------------------------------------------------------------------
// Profile column scorer divider
// Restoring divider, two quotient bits per cycle, truncating and saturating.
// ----------------------------------------------------------------------------
module pcs_div import pcs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_cmd_t cmd,
	output div_rsp_t rsp
);

	logic                busy_q;
	logic                done_q;
	logic                neg_q;
	logic [DIV_CW-1:0]   cnt_q;
	logic [DVD_W-1:0]    quo_q;
	logic [SCALE_W-1:0]  rem_q;
	logic [SCALE_W-1:0]  dvs_q;

	logic [ACC_W-1:0]    mag;
	logic [SCALE_W:0]    r1, r2;
	logic                ge1, ge2;
	logic [SCALE_W-1:0]  rem1, rem2;
	logic [DVD_W-1:0]    quo1, quo2;
	logic                pos_ovf, neg_ovf;

	assign mag = cmd.acc[ACC_W-1] ? ACC_W'(-cmd.acc) : ACC_W'(cmd.acc);

	// two restoring steps per cycle
	always_comb begin
		r1   = {rem_q, quo_q[DVD_W-1]};
		ge1  = r1 >= {1'b0, dvs_q};
		rem1 = ge1 ? SCALE_W'(r1 - {1'b0, dvs_q}) : r1[SCALE_W-1:0];
		quo1 = {quo_q[DVD_W-2:0], ge1};
		r2   = {rem1, quo1[DVD_W-1]};
		ge2  = r2 >= {1'b0, dvs_q};
		rem2 = ge2 ? SCALE_W'(r2 - {1'b0, dvs_q}) : r2[SCALE_W-1:0];
		quo2 = {quo1[DVD_W-2:0], ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CW'(1);
				if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			neg_q <= cmd.acc[ACC_W-1];
			dvs_q <= cmd.divisor;
			rem_q <= '0;
			quo_q <= DVD_W'(mag) << SCALE_FRAC;
		end else if (busy_q) begin
			rem_q <= rem2;
			quo_q <= quo2;
		end
	end

	// saturate the signed quotient to the score range
	assign pos_ovf = |quo_q[DVD_W-1:SCORE_W-1];
	assign neg_ovf = (|quo_q[DVD_W-1:SCORE_W]) ||
	                 (quo_q[SCORE_W-1] && (|quo_q[SCORE_W-2:0]));

	always_comb begin
		rsp.done = done_q;
		if (neg_q) begin
			rsp.score = neg_ovf ? {1'b1, {(SCORE_W-1){1'b0}}} : -quo_q[SCORE_W-1:0];
		end else begin
			rsp.score = pos_ovf ? {1'b0, {(SCORE_W-1){1'b1}}} : quo_q[SCORE_W-1:0];
		end
	end

endmodule

>>> hw/rtl/profile_column_scorer.sv
// ----------------------------------------------------------------------------
// Profile column scorer
// Fills a column of residue frequencies and emits one weighted score per residue.
// ----------------------------------------------------------------------------
// Operation: matrix writes and non-final frequencies are taken while idle; the
//   final frequency of a column starts, per residue, a MAC sweep and a divide.
// Throughput: n scores per column; masked columns emit one per cycle while the
//   result channel accepts. Requests stall until the column is done.
// Reset: clears control and configuration registers; the table and column
//   memories are not cleared and hold garbage until written.
module profile_column_scorer import pcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	pcs_in_if.sink            req,
	pcs_out_if.source         res,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MAC  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_EMIT = 3'd3;
	localparam logic [2:0] S_MASK = 3'd4;

	// configuration
	logic [ALPHA_W-1:0]        alpha_q;
	logic [SCALE_W-1:0]        scale_q;
	logic signed [SCORE_W-1:0] mask_q;

	// column control
	logic [2:0]                state_q;
	logic [CNT_W-1:0]          count_q;
	logic                      nz_q;
	logic [RES_W-1:0]          row_q;
	logic [CNT_W-1:0]          b_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [SCORE_W-1:0] score_q;

	// memories and MAC pipeline
	logic [ENTRY_BITS-1:0]        tbl_mem [TBL_DEPTH];
	logic [FREQ_BITS-1:0]         buf_mem [MAX_ALPHABET];
	logic signed [ENTRY_BITS-1:0] tbl_rd_s1;
	logic [FREQ_BITS-1:0]         buf_rd_s1;
	logic                         rd_vld_s1, rd_last_s1;
	logic signed [PROD_W-1:0]     prod_s2;
	logic                         prod_vld_s2, prod_last_s2;

	// result register
	logic                      res_vld_q;
	logic [RES_W-1:0]          res_residue_q;
	logic signed [SCORE_W-1:0] res_score_q;
	logic                      res_masked_q;
	logic                      res_last_q;

	logic [CNT_W-1:0]        n_act;
	logic [SCALE_W-1:0]      divisor;
	logic                    in_xfer;
	logic                    mat_wr;
	logic                    freq_wr;
	logic [CNT_W-1:0]        count_nxt;
	logic                    nz_nxt;
	logic                    col_done;
	logic                    issue;
	logic                    last_row;
	logic                    out_free;
	logic signed [ACC_W-1:0] acc_sum;
	div_cmd_t                div_cmd;
	div_rsp_t                div_rsp;

	// Out-of-range alphabet sizes clamp to 1..MAX_ALPHABET; a zero scale acts as one.
	always_comb begin
		if (alpha_q == '0) begin
			n_act = CNT_W'(1);
		end else if (int'(alpha_q) > MAX_ALPHABET) begin
			n_act = CNT_W'(MAX_ALPHABET);
		end else begin
			n_act = CNT_W'(alpha_q);
		end
	end

	assign divisor = (scale_q == '0) ? SCALE_W'(1) : scale_q;

	// Requests enter only between columns, so table writes never race the sweep.
	assign req.ready = (state_q == S_IDLE);
	assign in_xfer   = req.valid && req.ready;
	assign mat_wr    = in_xfer && (req.req_type == REQ_MATRIX) &&
	                   (int'(req.row_residue) < MAX_ALPHABET) &&
	                   (int'(req.col_residue) < MAX_ALPHABET);
	assign freq_wr   = in_xfer && (req.req_type == REQ_FREQ);
	assign count_nxt = count_q + CNT_W'(1);
	assign nz_nxt    = nz_q || (req.frequency != '0);
	assign col_done  = freq_wr && (count_nxt >= n_act);

	assign issue    = (state_q == S_MAC) && (b_q < n_act);
	assign last_row = ({1'b0, row_q} + CNT_W'(1)) == n_act;
	assign out_free = !res_vld_q || res.ready;
	assign acc_sum  = acc_q + ACC_W'(prod_s2);

	// Hand the finished row sum to the divider with the final product folded in.
	assign div_cmd.start   = (state_q == S_MAC) && prod_vld_s2 && prod_last_s2;
	assign div_cmd.acc     = acc_sum;
	assign div_cmd.divisor = divisor;

	pcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.rsp    (div_rsp)
	);

	// Configuration writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			scale_q <= SCALE_RST;
			mask_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ALPHABET: alpha_q <= cfg_data[ALPHA_W-1:0];
				CFG_SCALE:    scale_q <= cfg_data[SCALE_W-1:0];
				CFG_MASK:     mask_q  <= cfg_data[SCORE_W-1:0];
				default:      ;
			endcase
		end
	end

	// Table and column memories: one write port, one registered read port each.
	always_ff @(posedge clk) begin
		if (mat_wr) begin
			tbl_mem[{req.row_residue, req.col_residue}] <= req.matrix_entry;
		end
		tbl_rd_s1 <= tbl_mem[{row_q, b_q[RES_W-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (freq_wr) begin
			buf_mem[count_q[RES_W-1:0]] <= req.frequency;
		end
		buf_rd_s1 <= buf_mem[b_q[RES_W-1:0]];
	end

	// Multiply stage: frequency is unsigned, so pad a zero sign bit.
	always_ff @(posedge clk) begin
		prod_s2 <= $signed({1'b0, buf_rd_s1}) * tbl_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1    <= 1'b0;
			rd_last_s1   <= 1'b0;
			prod_vld_s2  <= 1'b0;
			prod_last_s2 <= 1'b0;
		end else begin
			rd_vld_s1    <= issue;
			rd_last_s1   <= issue && ((b_q + CNT_W'(1)) == n_act);
			prod_vld_s2  <= rd_vld_s1;
			prod_last_s2 <= rd_last_s1;
		end
	end

	// Column sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			nz_q      <= 1'b0;
			row_q     <= '0;
			b_q       <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (res.ready) begin
				res_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (freq_wr) begin
						if (col_done) begin
							count_q <= '0;
							nz_q    <= 1'b0;
							row_q   <= '0;
							b_q     <= '0;
							state_q <= nz_nxt ? S_MAC : S_MASK;
						end else begin
							count_q <= count_nxt;
							nz_q    <= nz_nxt;
						end
					end
				end
				S_MAC: begin
					if (issue) begin
						b_q <= b_q + CNT_W'(1);
					end
					if (div_cmd.start) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						res_vld_q <= 1'b1;
						if (last_row) begin
							state_q <= S_IDLE;
						end else begin
							row_q   <= row_q + RES_W'(1);
							b_q     <= '0;
							state_q <= S_MAC;
						end
					end
				end
				S_MASK: begin
					if (out_free) begin
						res_vld_q <= 1'b1;
						if (last_row) begin
							state_q <= S_IDLE;
						end else begin
							row_q <= row_q + RES_W'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Row accumulator and result payload; cleared at each row start.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE && col_done) ||
		    (state_q == S_EMIT && out_free)) begin
			acc_q <= '0;
		end else if (prod_vld_s2) begin
			acc_q <= acc_sum;
		end
		if (div_rsp.done) begin
			score_q <= div_rsp.score;
		end
		if ((state_q == S_EMIT || state_q == S_MASK) && out_free) begin
			res_residue_q <= row_q;
			res_score_q   <= (state_q == S_MASK) ? mask_q : score_q;
			res_masked_q  <= (state_q == S_MASK);
			res_last_q    <= last_row;
		end
	end

	assign res.valid          = res_vld_q;
	assign res.residue        = res_residue_q;
	assign res.score          = res_score_q;
	assign res.masked         = res_masked_q;
	assign res.last_of_column = res_last_q;

`ifndef SYNTHESIS
	// The final score of a column names the last residue of the alphabet.
	a_last_residue: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.last_of_column |-> ({1'b0, res.residue} + CNT_W'(1)) == n_act)
		else $error("last_of_column on wrong residue");

	// A masked score carries the configured mask value.
	a_mask_value: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.masked |-> res.score == mask_q)
		else $error("masked score differs from mask register");

	// The divider only finishes while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider result outside wait state");

	// Products only flow during a row sweep.
	a_prod_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		prod_vld_s2 |-> state_q == S_MAC)
		else $error("product outside row sweep");

	// The fill count never passes the buffer depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		freq_wr |=> int'(count_q) < MAX_ALPHABET)
		else $error("column fill count overflow");
`endif

endmodule
